>>> hdl/trb_pkg.sv
package trb_pkg;

    localparam int MAX_PHYS_BUTTONS = 32;
    localparam int WORD_W           = 32;
    localparam int UNIT_W           = 5;
    localparam int MAP_DEPTH        = 32;
    localparam int MAP_AW           = $clog2(MAP_DEPTH);
    localparam int BIT_AW           = $clog2(WORD_W);
    localparam int COUNT_W          = 6;
    localparam int DIV_W            = 3;
    localparam int CFG_INDEX_W      = 3;
    localparam int GROUP_SIZE       = 8;
    localparam int GROUPS           = (MAX_PHYS_BUTTONS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int QDEPTH           = 2;
    localparam int QAW              = $clog2(QDEPTH);
    localparam int QCW              = $clog2(QDEPTH + 1);

    localparam logic [DIV_W-1:0]  DIV_MIN  = 3'd1;
    localparam logic [DIV_W-1:0]  DIV_MAX  = 3'd4;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;

    // operation codes of an input beat
    localparam logic [1:0] OP_MAP_WRITE = 2'd0;
    localparam logic [1:0] OP_PAD_FRAME = 2'd1;
    localparam logic [1:0] OP_VSYNC     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_MASK   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_UNIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UP_UNIT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOWN_UNIT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_UNIT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_UNIT   = 3'd6;

    localparam logic [COUNT_W-1:0] RST_BUTTON_COUNT = 6'd16;
    localparam logic [UNIT_W-1:0]  RST_COMMAND_UNIT = 5'd8;
    localparam logic [UNIT_W-1:0]  RST_UP_UNIT      = 5'd0;
    localparam logic [UNIT_W-1:0]  RST_DOWN_UNIT    = 5'd1;
    localparam logic [UNIT_W-1:0]  RST_LEFT_UNIT    = 5'd2;
    localparam logic [UNIT_W-1:0]  RST_RIGHT_UNIT   = 5'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [UNIT_W-1:0] button_slot;
        logic [UNIT_W-1:0] target_unit;
        logic [WORD_W-1:0] pressed;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] buttons_out;
        logic [WORD_W-1:0] phase_a_word;
        logic [WORD_W-1:0] phase_b_word;
        logic [WORD_W-1:0] rapid_units;
        logic [WORD_W-1:0] rapid_marks;
        logic [DIV_W-1:0]  divider_out;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] button_count;
        logic [WORD_W-1:0]  phase_mask;
        logic [UNIT_W-1:0]  command_unit;
        logic [UNIT_W-1:0]  up_unit;
        logic [UNIT_W-1:0]  down_unit;
        logic [UNIT_W-1:0]  left_unit;
        logic [UNIT_W-1:0]  right_unit;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_MAP,
        KIND_PAD,
        KIND_TICK,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [UNIT_W-1:0] slot;
        logic [UNIT_W-1:0] target;
        logic [WORD_W-1:0] pressed;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_UNITS,
        BK_UPDATE,
        BK_GATE,
        BK_FINISH
    } back_state_t;

    function automatic logic [WORD_W-1:0] unit_bit(input logic [UNIT_W-1:0] u);
        return {{(WORD_W-1){1'b0}}, 1'b1} << u;
    endfunction

    // buttons in use: count clamps to the build limit
    function automatic logic [WORD_W-1:0] act_mask(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] n;
        n = (cnt > COUNT_W'(MAX_PHYS_BUTTONS)) ? COUNT_W'(MAX_PHYS_BUTTONS) : cnt;
        if (n >= COUNT_W'(WORD_W)) begin
            return ALL_ONES;
        end
        return ({{(WORD_W-1){1'b0}}, 1'b1} << n) - {{(WORD_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

>>> hdl/trb_front.sv
module trb_front
    import trb_pkg::*;
(
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // classify the beat and drop pressed bits of buttons not in use
    always_comb begin
        q_cmd.slot    = s_data.button_slot;
        q_cmd.target  = s_data.target_unit;
        q_cmd.pressed = s_data.pressed & act_mask(cfg.button_count);
        case (s_data.operation)
            OP_MAP_WRITE: q_cmd.kind = KIND_MAP;
            OP_PAD_FRAME: q_cmd.kind = KIND_PAD;
            OP_VSYNC:     q_cmd.kind = KIND_TICK;
            default:      q_cmd.kind = KIND_NONE;
        endcase
    end

endmodule

>>> hdl/trb_queue.sv
module trb_queue
    import trb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/trb_back.sv
module trb_back
    import trb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    back_state_t       state_reg, state_next;

    logic [UNIT_W-1:0] unit_map_reg [MAP_DEPTH];
    logic [WORD_W-1:0] raw_now_reg, raw_prev_reg, units_now_reg, units_prev_reg;
    logic [WORD_W-1:0] flags_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [WORD_W-1:0] fc_reg;
    logic [1:0]        mod3_reg;
    logic              par3_reg;
    logic [WORD_W-1:0] word_a_reg, word_b_reg, ru_reg;
    logic              is_pad_reg;

    logic [WORD_W-1:0] grp_u_reg [GROUPS];
    logic [WORD_W-1:0] grp_a_reg [GROUPS];
    logic [WORD_W-1:0] grp_b_reg [GROUPS];
    logic [WORD_W-1:0] grp_ru_reg [GROUPS];
    logic [WORD_W-1:0] grp_r_reg [GROUPS];

    logic [WORD_W-1:0] grp_u_next [GROUPS];
    logic [WORD_W-1:0] grp_a_next [GROUPS];
    logic [WORD_W-1:0] grp_b_next [GROUPS];
    logic [WORD_W-1:0] grp_ru_next [GROUPS];
    logic [WORD_W-1:0] grp_r_next [GROUPS];

    logic [WORD_W-1:0] units_next, flags_next;
    logic [DIV_W-1:0]  div_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg;

    logic do_apply, do_units, do_update, do_gate, do_load;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        do_apply   = 1'b0;
        do_units   = 1'b0;
        do_update  = 1'b0;
        do_gate    = 1'b0;
        do_load    = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    do_apply   = 1'b1;
                    state_next = (q_cmd.kind == KIND_PAD) ? BK_UNITS : BK_GATE;
                end
            end
            BK_UNITS: begin
                do_units   = 1'b1;
                state_next = BK_UPDATE;
            end
            BK_UPDATE: begin
                do_update  = 1'b1;
                state_next = BK_GATE;
            end
            BK_GATE: begin
                do_gate    = 1'b1;
                state_next = BK_FINISH;
            end
            BK_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    do_load    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // first tree level: unit word of the latched raw buttons, one group of eight per leaf
    always_comb begin
        int idx;
        for (int g = 0; g < GROUPS; g++) begin
            grp_u_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                idx = g * GROUP_SIZE + j;
                if (idx < MAX_PHYS_BUTTONS) begin
                    if (raw_now_reg[idx[BIT_AW-1:0]]) begin
                        grp_u_next[g] = grp_u_next[g] | unit_bit(unit_map_reg[idx[MAP_AW-1:0]]);
                    end
                end
            end
        end
    end

    // edges, mark toggles and divider step
    always_comb begin
        logic [WORD_W-1:0] trig_u, trig_r, dirs;
        units_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            units_next = units_next | grp_u_reg[g];
        end
        trig_u = units_next & ~units_prev_reg;
        trig_r = raw_now_reg & ~raw_prev_reg;
        dirs   = unit_bit(cfg.up_unit) | unit_bit(cfg.down_unit) | unit_bit(cfg.left_unit)
               | unit_bit(cfg.right_unit) | unit_bit(cfg.command_unit);
        flags_next = flags_reg;
        div_next   = div_reg;
        if (((units_next & unit_bit(cfg.command_unit)) != '0)
                && ((trig_u != '0) || (trig_r != '0))) begin
            if ((trig_r != '0) && ((dirs & trig_u) == '0)) begin
                flags_next = flags_reg ^ trig_r;
            end
            if (trig_u[cfg.up_unit] && (div_next > DIV_MIN)) begin
                div_next = div_next - DIV_W'(1);
            end
            if (trig_u[cfg.down_unit] && (div_next < DIV_MAX)) begin
                div_next = div_next + DIV_W'(1);
            end
        end
    end

    // second tree level inputs: phase words, rapid units and gated word
    always_comb begin
        int                idx;
        logic [WORD_W-1:0] act, gate, m0, m;
        logic              par, rap;
        act = act_mask(cfg.button_count);
        case (div_reg)
            3'd2:    par = fc_reg[1];
            3'd3:    par = par3_reg;
            3'd4:    par = fc_reg[2];
            default: par = fc_reg[0];
        endcase
        gate = par ? cfg.phase_mask : ~cfg.phase_mask;
        for (int g = 0; g < GROUPS; g++) begin
            grp_a_next[g]  = '0;
            grp_b_next[g]  = '0;
            grp_ru_next[g] = '0;
            grp_r_next[g]  = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                idx = g * GROUP_SIZE + j;
                if (idx < MAX_PHYS_BUTTONS) begin
                    m0  = unit_bit(unit_map_reg[idx[MAP_AW-1:0]]);
                    m   = (raw_now_reg[idx[BIT_AW-1:0]] && act[idx[BIT_AW-1:0]]) ? m0 : '0;
                    rap = flags_reg[idx[BIT_AW-1:0]] && act[idx[BIT_AW-1:0]];
                    if (rap) begin
                        grp_a_next[g]  = grp_a_next[g] | (m & cfg.phase_mask);
                        grp_b_next[g]  = grp_b_next[g] | (m & ~cfg.phase_mask);
                        grp_ru_next[g] = grp_ru_next[g] | m0;
                        grp_r_next[g]  = grp_r_next[g] | (m & gate);
                    end else begin
                        grp_a_next[g] = grp_a_next[g] | m;
                        grp_b_next[g] = grp_b_next[g] | m;
                        grp_r_next[g] = grp_r_next[g] | m;
                    end
                end
            end
        end
    end

    always_comb begin
        logic [WORD_W-1:0] a, b, ru, r;
        a  = '0;
        b  = '0;
        ru = '0;
        r  = '0;
        for (int g = 0; g < GROUPS; g++) begin
            a  = a | grp_a_reg[g];
            b  = b | grp_b_reg[g];
            ru = ru | grp_ru_reg[g];
            r  = r | grp_r_reg[g];
        end
        out_next.buttons_out  = r;
        out_next.phase_a_word = is_pad_reg ? a : word_a_reg;
        out_next.phase_b_word = is_pad_reg ? b : word_b_reg;
        out_next.rapid_units  = is_pad_reg ? ru : ru_reg;
        out_next.rapid_marks  = flags_reg;
        out_next.divider_out  = div_reg;
    end

    // block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAP_DEPTH; k++) begin
                unit_map_reg[k] <= '0;
            end
            raw_now_reg    <= '0;
            raw_prev_reg   <= '0;
            units_now_reg  <= '0;
            units_prev_reg <= '0;
            flags_reg      <= '0;
            div_reg        <= DIV_MIN;
            fc_reg         <= '0;
            mod3_reg       <= '0;
            par3_reg       <= 1'b0;
            word_a_reg     <= '0;
            word_b_reg     <= '0;
            ru_reg         <= '0;
            is_pad_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (do_apply) begin
                is_pad_reg <= (q_cmd.kind == KIND_PAD);
                case (q_cmd.kind)
                    KIND_MAP: begin
                        unit_map_reg[q_cmd.slot] <= q_cmd.target;
                    end
                    KIND_PAD: begin
                        raw_prev_reg   <= raw_now_reg;
                        units_prev_reg <= units_now_reg;
                        raw_now_reg    <= q_cmd.pressed;
                    end
                    KIND_TICK: begin
                        // track count / 3 parity alongside the counter; restart on wrap
                        if (fc_reg == ALL_ONES) begin
                            fc_reg   <= '0;
                            mod3_reg <= '0;
                            par3_reg <= 1'b0;
                        end else begin
                            fc_reg <= fc_reg + WORD_W'(1);
                            if (mod3_reg == 2'd2) begin
                                mod3_reg <= '0;
                                par3_reg <= !par3_reg;
                            end else begin
                                mod3_reg <= mod3_reg + 2'd1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (do_update) begin
                units_now_reg <= units_next;
                flags_reg     <= flags_next;
                div_reg       <= div_next;
            end
            if (do_load) begin
                out_valid_reg <= 1'b1;
                if (is_pad_reg) begin
                    word_a_reg <= out_next.phase_a_word;
                    word_b_reg <= out_next.phase_b_word;
                    ru_reg     <= out_next.rapid_units;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tree leaves and result payload
    always_ff @(posedge aclk) begin
        if (do_units) begin
            grp_u_reg <= grp_u_next;
        end
        if (do_gate) begin
            grp_a_reg  <= grp_a_next;
            grp_b_reg  <= grp_b_next;
            grp_ru_reg <= grp_ru_next;
            grp_r_reg  <= grp_r_next;
        end
        if (do_load) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> hdl/gamepad_turbo_fire_controller_core.sv
// Turbo-fire controller for a game pad. Each input beat is a map write (button -> unit bit),
// a pad frame (pressed buttons) or a vsync tick, and each returns exactly one result beat
// with the gated button word, the phase A/B words, the rapid units, the rapid marks and
// the frame divider. Beats enter a two-entry queue and are then run one at a time:
// a pad frame steps through the units, update, gate and finish states to its result, a
// map write, vsync tick or unused code through gate and finish only. The first of two
// registered OR trees over the button map (eight buttons per leaf) forms the unit word of a
// pad frame, the second the phase and gated words of every beat, with the edge and divider
// update in between. The front keeps taking beats while the queue has room; a finished
// result waits in its output register; the next beat runs on and waits in its finish state.
// Write configuration only while no beat is in flight.

module gamepad_turbo_fire_controller_core
    import trb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_wdata
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    // configuration registers: hold the reset values until written; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.button_count <= RST_BUTTON_COUNT;
            cfg_reg.phase_mask   <= '0;
            cfg_reg.command_unit <= RST_COMMAND_UNIT;
            cfg_reg.up_unit      <= RST_UP_UNIT;
            cfg_reg.down_unit    <= RST_DOWN_UNIT;
            cfg_reg.left_unit    <= RST_LEFT_UNIT;
            cfg_reg.right_unit   <= RST_RIGHT_UNIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BUTTON_COUNT: cfg_reg.button_count <= cfg_wdata[COUNT_W-1:0];
                REG_PHASE_MASK:   cfg_reg.phase_mask   <= cfg_wdata;
                REG_COMMAND_UNIT: cfg_reg.command_unit <= cfg_wdata[UNIT_W-1:0];
                REG_UP_UNIT:      cfg_reg.up_unit      <= cfg_wdata[UNIT_W-1:0];
                REG_DOWN_UNIT:    cfg_reg.down_unit    <= cfg_wdata[UNIT_W-1:0];
                REG_LEFT_UNIT:    cfg_reg.left_unit    <= cfg_wdata[UNIT_W-1:0];
                REG_RIGHT_UNIT:   cfg_reg.right_unit   <= cfg_wdata[UNIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify beats, mask unused buttons
    trb_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // short queue that lets front and back stall on their own
    trb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd)
    );

    // back: map, edges, marks, divider, phase words and output register
    trb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hdl/trb_checker.sv
module trb_checker
    import trb_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_divider_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.divider_out >= DIV_MIN) && (m_data.divider_out <= DIV_MAX)))
        else $error("divider out of range");

    // phase words differ only in units driven by rapid buttons
    a_phase_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_data.phase_a_word ^ m_data.phase_b_word) & ~m_data.rapid_units) == '0))
        else $error("phase words differ outside rapid units");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind gamepad_turbo_fire_controller_core trb_checker u_trb_checker (.*);

>>> tb/turbo_fire_checker.sv
`timescale 1ns / 100ps

module turbo_fire_checker
    import trb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_wdata,
    output int                     fail_count,
    output int                     pending_count,
    output int                     result_count
);

    localparam int PRINT_CAP = 200;

    // shadow registers
    logic [COUNT_W-1:0] sh_count;
    logic [WORD_W-1:0]  sh_phase_mask;
    logic [UNIT_W-1:0]  sh_cmd, sh_up, sh_down, sh_left, sh_right;

    // predicted block state
    logic [UNIT_W-1:0]  unit_of [MAP_DEPTH];
    logic [WORD_W-1:0]  raw_now, raw_prev, units_now, units_prev, marks;
    logic [WORD_W-1:0]  word_a, word_b, rapid_word, frame_cnt;
    logic [DIV_W-1:0]   divider;

    out_item_t expected_pad_results[$];
    int        mismatches   = 0;
    int        results_seen = 0;

    function automatic logic [WORD_W-1:0] onehot_unit(input logic [UNIT_W-1:0] u);
        return 32'd1 << u;
    endfunction

    task automatic predict_turbo_step(input in_item_t beat, output out_item_t res);
        logic [WORD_W-1:0] units, rise_u, rise_r, steer, m0, m;
        logic [WORD_W-1:0] acc_a, acc_b, acc_r, gate, quot, gated;
        int n;
        n = (sh_count > COUNT_W'(MAX_PHYS_BUTTONS)) ? MAX_PHYS_BUTTONS : int'(sh_count);
        case (beat.operation)
            OP_MAP_WRITE: unit_of[beat.button_slot] = beat.target_unit;
            OP_PAD_FRAME: begin
                raw_prev   = raw_now;
                units_prev = units_now;
                raw_now    = (n >= WORD_W) ? beat.pressed
                                           : beat.pressed & ((32'd1 << n) - 32'd1);
                units = '0;
                for (int i = 0; i < n; i++) begin
                    if (raw_now[i]) units |= onehot_unit(unit_of[i]);
                end
                units_now = units;
                rise_u = units_now & ~units_prev;
                rise_r = raw_now & ~raw_prev;
                steer  = onehot_unit(sh_up) | onehot_unit(sh_down) | onehot_unit(sh_left)
                       | onehot_unit(sh_right) | onehot_unit(sh_cmd);
                // act only while command is held and something rose
                if (units_now[sh_cmd] && (rise_u != '0 || rise_r != '0)) begin
                    if (rise_r != '0 && (steer & rise_u) == '0) marks ^= rise_r;
                    if (rise_u[sh_up] && divider > DIV_MIN) divider = divider - 3'd1;
                    if (rise_u[sh_down] && divider < DIV_MAX) divider = divider + 3'd1;
                end
                acc_a = '0;
                acc_b = '0;
                acc_r = '0;
                for (int i = 0; i < n; i++) begin
                    m0 = onehot_unit(unit_of[i]);
                    m  = raw_now[i] ? m0 : '0;
                    if (marks[i]) begin
                        acc_a |= m & sh_phase_mask;
                        acc_b |= m & ~sh_phase_mask;
                        acc_r |= m0;
                    end else begin
                        acc_a |= m;
                        acc_b |= m;
                    end
                end
                word_a     = acc_a;
                word_b     = acc_b;
                rapid_word = acc_r;
            end
            OP_VSYNC: frame_cnt = frame_cnt + 32'd1;
            default: ;
        endcase
        // gate rapid units by the parity of count / divider
        quot  = frame_cnt / WORD_W'(divider);
        gate  = quot[0] ? sh_phase_mask : ~sh_phase_mask;
        gated = '0;
        for (int i = 0; i < n; i++) begin
            m = raw_now[i] ? onehot_unit(unit_of[i]) : '0;
            gated |= marks[i] ? (m & gate) : m;
        end
        res.buttons_out  = gated;
        res.phase_a_word = word_a;
        res.phase_b_word = word_b;
        res.rapid_units  = rapid_word;
        res.rapid_marks  = marks;
        res.divider_out  = divider;
    endtask

    task automatic compare_field(input string fname, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("t=%0t %s mismatch: expected %h actual %h", $time, fname, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want, fresh;
        if (!aresetn) begin
            sh_count      = RST_BUTTON_COUNT;
            sh_phase_mask = '0;
            sh_cmd        = RST_COMMAND_UNIT;
            sh_up         = RST_UP_UNIT;
            sh_down       = RST_DOWN_UNIT;
            sh_left       = RST_LEFT_UNIT;
            sh_right      = RST_RIGHT_UNIT;
            for (int i = 0; i < MAP_DEPTH; i++) unit_of[i] = '0;
            raw_now    = '0;
            raw_prev   = '0;
            units_now  = '0;
            units_prev = '0;
            marks      = '0;
            word_a     = '0;
            word_b     = '0;
            rapid_word = '0;
            frame_cnt  = '0;
            divider    = DIV_MIN;
            expected_pad_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BUTTON_COUNT: sh_count      = cfg_wdata[COUNT_W-1:0];
                    REG_PHASE_MASK:   sh_phase_mask = cfg_wdata;
                    REG_COMMAND_UNIT: sh_cmd        = cfg_wdata[UNIT_W-1:0];
                    REG_UP_UNIT:      sh_up         = cfg_wdata[UNIT_W-1:0];
                    REG_DOWN_UNIT:    sh_down       = cfg_wdata[UNIT_W-1:0];
                    REG_LEFT_UNIT:    sh_left       = cfg_wdata[UNIT_W-1:0];
                    REG_RIGHT_UNIT:   sh_right      = cfg_wdata[UNIT_W-1:0];
                    default: ;
                endcase
            end
            // retire the result beat before queuing a new expectation
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_pad_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP) begin
                        $display("t=%0t result beat with nothing expected: actual %h",
                                 $time, m_data);
                    end
                end else begin
                    want = expected_pad_results.pop_front();
                    compare_field("buttons_out", want.buttons_out, m_data.buttons_out);
                    compare_field("phase_a_word", want.phase_a_word, m_data.phase_a_word);
                    compare_field("phase_b_word", want.phase_b_word, m_data.phase_b_word);
                    compare_field("rapid_units", want.rapid_units, m_data.rapid_units);
                    compare_field("rapid_marks", want.rapid_marks, m_data.rapid_marks);
                    compare_field("divider_out", WORD_W'(want.divider_out),
                                  WORD_W'(m_data.divider_out));
                end
            end
            if (s_valid && s_ready) begin
                predict_turbo_step(s_data, fresh);
                expected_pad_results.push_back(fresh);
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_pad_results.size();
        result_count  <= results_seen;
    end

endmodule

>>> tb/gamepad_turbo_fire_controller_core_tb.sv
`timescale 1ns / 100ps

module gamepad_turbo_fire_controller_core_tb;
    import trb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PHASES        = 7;
    localparam int PHASE_BEATS   = 232;
    localparam int SETUP_BEATS   = 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 160;

    // steering unit slots of the stimulus shadow
    localparam int ST_CMD   = 0;
    localparam int ST_UP    = 1;
    localparam int ST_DOWN  = 2;
    localparam int ST_LEFT  = 3;
    localparam int ST_RIGHT = 4;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_wdata = '0;

    int fail_count, pending_count, result_count;
    int cycle_cnt = 0;

    // stimulus-side view of the map and the steering registers, used only to
    // aim pad frames at the command and direction buttons
    logic [UNIT_W-1:0] slot_target [MAP_DEPTH];
    logic [UNIT_W-1:0] steer_units [5];
    int                lim_buttons;
    logic [WORD_W-1:0] held;
    bit                send_quiet = 1'b0;
    bit                recv_quiet = 1'b0;
    int n_map = 0, n_pad = 0, n_tick = 0, n_unused = 0, n_settings = 0;

    gamepad_turbo_fire_controller_core u_dut (.*);

    turbo_fire_checker u_checker (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Idle stretches come in spells: a quiet side takes every beat at once.
    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // Offer one input beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic [1:0] op, input logic [UNIT_W-1:0] slot,
                             input logic [UNIT_W-1:0] target,
                             input logic [WORD_W-1:0] pressed);
        in_item_t beat;
        int       gap;
        beat.operation   = op;
        beat.button_slot = slot;
        beat.target_unit = target;
        beat.pressed     = pressed;
        case (op)
            OP_MAP_WRITE: begin
                n_map++;
                slot_target[slot] = target;
            end
            OP_PAD_FRAME: n_pad++;
            OP_VSYNC:     n_tick++;
            default:      n_unused++;
        endcase
        if ($urandom_range(0, 99) < 3) send_quiet = !send_quiet;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every result, then let the pipeline drain fully.
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; fill the bits above its width with noise.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] val, input int width);
        logic [WORD_W-1:0] keep;
        keep = (width >= WORD_W) ? ALL_ONES : ((32'd1 << width) - 32'd1);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= (val & keep) | ($urandom & ~keep);
        @(posedge aclk);
    endtask

    // Result side: random stalls, plus two long hold-offs that back the
    // block up until it refuses input beats.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) < 3) recv_quiet = !recv_quiet;
            gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if (taken == 300 || taken == 1100) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Run stopped by the cycle limit at %0d cycles", cycle_cnt);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int                 k, p, r, s, n_tog;
        int                 hits[$];
        logic [COUNT_W-1:0] cnt;
        logic [WORD_W-1:0]  mask, in_use, word;
        logic [UNIT_W-1:0]  tgt;

        for (k = 0; k < MAP_DEPTH; k++) slot_target[k] = '0;
        steer_units = '{RST_COMMAND_UNIT, RST_UP_UNIT, RST_DOWN_UNIT,
                        RST_LEFT_UNIT, RST_RIGHT_UNIT};
        lim_buttons = int'(RST_BUTTON_COUNT);
        held        = '0;

        // start in reset, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on reset settings: 16 buttons, command on unit 8,
        // up/down/left/right on units 0..3, every unit in phase B.
        send_beat(OP_MAP_WRITE, 5'd0, 5'd8, 32'h0);
        send_beat(OP_MAP_WRITE, 5'd1, 5'd0, ALL_ONES);
        send_beat(OP_MAP_WRITE, 5'd2, 5'd1, 32'h0);
        send_beat(OP_MAP_WRITE, 5'd3, 5'd2, ALL_ONES);
        send_beat(OP_MAP_WRITE, 5'd4, 5'd3, 32'h0);
        send_beat(OP_MAP_WRITE, 5'd5, 5'd5, ALL_ONES);
        send_beat(OP_MAP_WRITE, 5'd15, 5'd31, 32'h0);
        // slot beyond the button count: its mapping must never show
        send_beat(OP_MAP_WRITE, 5'd31, 5'd30, ALL_ONES);
        // command pressed alone: its own edge must not toggle any mark
        send_beat(OP_PAD_FRAME, 5'd31, 5'd31, 32'h0000_0001);
        // command held, button 5 rises: toggle its mark
        send_beat(OP_PAD_FRAME, 5'd0, 5'd31, 32'h0000_0021);
        // up rises with command: no mark toggle, divider stays at its floor
        send_beat(OP_PAD_FRAME, 5'd31, 5'd0, 32'h0000_0023);
        // step the divider up to its ceiling with three down edges
        for (k = 0; k < 3; k++) begin
            send_beat(OP_PAD_FRAME, 5'd0, 5'd0, 32'h0000_0021);
            send_beat(OP_PAD_FRAME, 5'd31, 5'd31, 32'h0000_0025);
        end
        // up rises again: step back down
        send_beat(OP_PAD_FRAME, 5'd0, 5'd31, 32'h0000_0023);
        send_beat(OP_VSYNC, 5'd31, 5'd31, ALL_ONES);
        send_beat(OP_VSYNC, 5'd0, 5'd0, 32'h0);
        // remap a pressed button between frames
        send_beat(OP_MAP_WRITE, 5'd5, 5'd7, 32'h0);
        // everything pressed: bits beyond the count read as released
        send_beat(OP_PAD_FRAME, 5'd31, 5'd31, ALL_ONES);
        send_beat(OP_UNUSED, 5'd31, 5'd31, ALL_ONES);
        send_beat(OP_PAD_FRAME, 5'd0, 5'd0, 32'h0);
        send_beat(OP_VSYNC, 5'd0, 5'd0, 32'h0);

        for (p = 0; p < PHASES; p++) begin
            settle_idle();

            // pick this phase's register setting; extremes first
            cnt  = COUNT_W'($urandom_range(0, 63));
            mask = $urandom;
            for (k = 0; k < 5; k++) steer_units[k] = UNIT_W'($urandom_range(0, 31));
            case (p)
                0: begin
                    cnt         = 6'd32;
                    mask        = ALL_ONES;
                    steer_units = '{5'd31, 5'd30, 5'd29, 5'd28, 5'd0};
                end
                1: begin
                    cnt  = 6'd0;
                    mask = '0;
                end
                2: cnt = 6'd63;
                3: cnt = COUNT_W'($urandom_range(1, 31));
                4: cnt = 6'd33;
                5: begin
                    cnt                 = RST_BUTTON_COUNT;
                    steer_units[ST_CMD] = '0;
                end
                default: ;
            endcase
            write_reg(REG_BUTTON_COUNT, WORD_W'(cnt), COUNT_W);
            write_reg(REG_PHASE_MASK, mask, WORD_W);
            write_reg(REG_COMMAND_UNIT, WORD_W'(steer_units[ST_CMD]), UNIT_W);
            write_reg(REG_UP_UNIT, WORD_W'(steer_units[ST_UP]), UNIT_W);
            write_reg(REG_DOWN_UNIT, WORD_W'(steer_units[ST_DOWN]), UNIT_W);
            write_reg(REG_LEFT_UNIT, WORD_W'(steer_units[ST_LEFT]), UNIT_W);
            write_reg(REG_RIGHT_UNIT, WORD_W'(steer_units[ST_RIGHT]), UNIT_W);
            cfg_wr_en <= 1'b0;
            n_settings++;
            lim_buttons = (cnt > COUNT_W'(MAX_PHYS_BUTTONS)) ? MAX_PHYS_BUTTONS : int'(cnt);
            in_use = (lim_buttons >= WORD_W) ? ALL_ONES : ((32'd1 << lim_buttons) - 32'd1);
            held = '0;

            // wire slots 0..4 to command and directions, plus a few spares
            for (k = 0; k < 5; k++) begin
                send_beat(OP_MAP_WRITE, UNIT_W'(k), steer_units[k], $urandom);
            end
            for (k = 0; k < SETUP_BEATS - 5; k++) begin
                send_beat(OP_MAP_WRITE, UNIT_W'($urandom_range(5, 31)),
                          UNIT_W'($urandom_range(0, 31)), $urandom);
            end

            for (k = 0; k < PHASE_BEATS - SETUP_BEATS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    tgt = ($urandom_range(0, 1) != 0) ? steer_units[$urandom_range(0, 4)]
                                                      : UNIT_W'($urandom_range(0, 31));
                    send_beat(OP_MAP_WRITE, UNIT_W'($urandom_range(0, 31)), tgt, $urandom);
                end else if (r < 60) begin
                    // Evolve the held buttons a step at a time so that edges
                    // come with the command held; sometimes send pure noise.
                    r = $urandom_range(0, 99);
                    if (r < 12) begin
                        word = $urandom;
                    end else begin
                        if (r < 17) held = '0;
                        if (lim_buttons > 0) begin
                            n_tog = $urandom_range(1, 2);
                            for (int t = 0; t < n_tog; t++) begin
                                s = ($urandom_range(0, 1) != 0)
                                  ? $urandom_range(0, (lim_buttons < 8 ? lim_buttons : 8) - 1)
                                  : $urandom_range(0, lim_buttons - 1);
                                held[s] = ~held[s];
                            end
                            if (r < 60) begin
                                hits.delete();
                                for (int i = 0; i < lim_buttons; i++) begin
                                    if (slot_target[i] == steer_units[ST_CMD]) hits.push_back(i);
                                end
                                if (hits.size() > 0) begin
                                    held[hits[$urandom_range(0, hits.size() - 1)]] = 1'b1;
                                end
                            end
                        end
                        held = held & in_use;
                        // stray presses on buttons that are not in use
                        word = held | ((r < 35) ? ($urandom & ~in_use) : '0);
                    end
                    send_beat(OP_PAD_FRAME, UNIT_W'($urandom_range(0, 31)),
                              UNIT_W'($urandom_range(0, 31)), word);
                end else if (r < 95) begin
                    send_beat(OP_VSYNC, UNIT_W'($urandom_range(0, 31)),
                              UNIT_W'($urandom_range(0, 31)), $urandom);
                end else begin
                    send_beat(OP_UNUSED, UNIT_W'($urandom_range(0, 31)),
                              UNIT_W'($urandom_range(0, 31)), $urandom);
                end
            end
        end

        settle_idle();

        $display("Sent %0d beats: %0d map writes, %0d pad frames, %0d vsync ticks, %0d unused",
                 n_map + n_pad + n_tick + n_unused, n_map, n_pad, n_tick, n_unused);
        $display("Checked %0d results over %0d register settings, %0d mismatches",
                 result_count, n_settings, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> gamepad_turbo_fire_controller_core.f
hdl/trb_pkg.sv
hdl/trb_front.sv
hdl/trb_queue.sv
hdl/trb_back.sv
hdl/gamepad_turbo_fire_controller_core.sv
hdl/trb_checker.sv
tb/turbo_fire_checker.sv
tb/gamepad_turbo_fire_controller_core_tb.sv
